// ===== rtl/dpq_pkg.sv =====
package dpq_pkg;

    localparam int CAP_W    = 10;
    localparam int CAPACITY = 1 << CAP_W;
    localparam int CNT_W    = CAP_W + 1;
    localparam int DATA_W   = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [DATA_W-1:0] DEL_MIN_CODE = '1;

    typedef struct packed {
        logic              rd_en;
        logic [CAP_W-1:0]  rd_addr;
        logic              wr_en;
        logic [CAP_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

// ===== rtl/double_ended_priority_queue.sv =====
// Double-ended priority queue of up to CAPACITY (1024) signed 32-bit values,
// duplicates allowed. Each input item (insert, delete minimum or maximum,
// clear) returns one result item with the empty flag, the maximum, the
// minimum, the count and a flag for an insert refused on a full queue. The
// values sit sorted in a single ring-addressed RAM with a registered read:
// deleting the minimum advances the ring head, deleting the maximum
// shortens the count. An insert binary-searches the RAM (a read and a
// compare for each step), then moves every larger value up by one entry
// at one entry a cycle, then writes the new value; that move is what sets
// the worst-case rate. One item is handled at a time; a new item is taken
// once the previous result has been taken.
module double_ended_priority_queue
    import dpq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_is_empty,
    output logic signed [DATA_W-1:0] m_max_value,
    output logic signed [DATA_W-1:0] m_min_value,
    output logic [CNT_W-1:0]         m_held_count,
    output logic                     m_dropped
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_SHIFT, ST_WRITE,
        ST_FIN, ST_RD_MAX, ST_CAP_MAX, ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CAP_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [CNT_W-1:0]         nxt_reg, nxt_next;
    logic [CNT_W-1:0]         dst_reg, dst_next;
    logic                     pend_reg, pend_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     drop_reg, drop_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     empty_reg, empty_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic [CNT_W-1:0]         cnt_out_reg, cnt_out_next;

    mem_req_t                 req;
    logic signed [DATA_W-1:0] rd_data;
    logic [CNT_W-1:0]         mid_calc;
    logic [CNT_W-1:0]         nxt_dec;

    dpq_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_is_empty   = empty_reg;
    assign m_max_value  = max_reg;
    assign m_min_value  = min_reg;
    assign m_held_count = cnt_out_reg;
    assign m_dropped    = drop_reg;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign nxt_dec  = nxt_reg - CNT_W'(1);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        nxt_next     = nxt_reg;
        dst_next     = dst_reg;
        pend_next    = pend_reg;
        value_next   = value_reg;
        drop_next    = drop_reg;
        m_valid_next = m_valid_reg;
        empty_next   = empty_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        cnt_out_next = cnt_out_reg;
        req          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = s_value;
                    drop_next  = 1'b0;
                    state_next = ST_FIN;
                    case (s_action)
                        ACT_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                drop_next = 1'b1;
                            end else begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                state_next = ST_SRCH_RD;
                            end
                        end
                        ACT_DELETE: begin
                            if (count_reg != '0) begin
                                // minimum sits at the head, maximum at the tail
                                if (s_value == DEL_MIN_CODE) begin
                                    head_next = head_reg + CAP_W'(1);
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    mid_next    = mid_calc;
                    req.rd_en   = 1'b1;
                    req.rd_addr = head_reg + mid_calc[CAP_W-1:0];
                    state_next  = ST_SRCH_CMP;
                end else begin
                    nxt_next   = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SRCH_CMP: begin
                if (rd_data <= value_reg) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH_RD;
            end
            ST_SHIFT: begin
                // write back the entry read last cycle one place higher
                if (pend_reg) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = head_reg + dst_reg[CAP_W-1:0];
                    req.wr_data = rd_data;
                end
                if (nxt_reg > lo_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = head_reg + nxt_dec[CAP_W-1:0];
                    dst_next    = nxt_reg;
                    nxt_next    = nxt_dec;
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                req.wr_en   = 1'b1;
                req.wr_addr = head_reg + lo_reg[CAP_W-1:0];
                req.wr_data = value_reg;
                count_next  = count_reg + CNT_W'(1);
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                cnt_out_next = count_reg;
                if (count_reg == '0) begin
                    empty_next   = 1'b1;
                    max_next     = '0;
                    min_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = head_reg;
                    state_next  = ST_RD_MAX;
                end
            end
            ST_RD_MAX: begin
                min_next    = rd_data;
                req.rd_en   = 1'b1;
                req.rd_addr = head_reg + count_reg[CAP_W-1:0] - CAP_W'(1);
                state_next  = ST_CAP_MAX;
            end
            ST_CAP_MAX: begin
                max_next     = rd_data;
                empty_next   = 1'b0;
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        nxt_reg     <= nxt_next;
        dst_reg     <= dst_next;
        value_reg   <= value_next;
        drop_reg    <= drop_next;
        empty_reg   <= empty_next;
        max_reg     <= max_next;
        min_reg     <= min_next;
        cnt_out_reg <= cnt_out_next;
    end

endmodule

// ===== rtl/dpq_store.sv =====
module dpq_store
    import dpq_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/double_ended_priority_queue_test.sv =====
module double_ended_priority_queue_test;
    import dpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]        action;
        logic [DATA_W-1:0] value;
        int                phase;  // selects the idling mix while this item is presented
        bit                pause;  // hold off until every queued report has come back
    } op_t;

    typedef struct {
        logic              is_empty;
        logic [DATA_W-1:0] max_value;
        logic [DATA_W-1:0] min_value;
        logic [CNT_W-1:0]  held_count;
        logic              dropped;
    } report_t;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_action = ACT_INSERT;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_is_empty;
    logic signed [DATA_W-1:0] m_max_value;
    logic signed [DATA_W-1:0] m_min_value;
    logic [CNT_W-1:0]         m_held_count;
    logic                     m_dropped;

    op_t     pending_ops[$];
    report_t queued_reports[$];
    int      sorted_vals[$];   // the predicted contents, ascending
    int      cur_phase = 0;
    int      mismatches = 0;
    int      reports_seen = 0;
    int      drops_seen = 0;
    int      idle_cycles = 0;

    // sender and receiver idle percentages for each phase
    int send_idle[3] = '{36, 74, 0};
    int recv_idle[3] = '{74, 36, 0};

    double_ended_priority_queue i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_empty  (m_is_empty),
        .m_max_value (m_max_value),
        .m_min_value (m_min_value),
        .m_held_count(m_held_count),
        .m_dropped   (m_dropped)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the sorted multiset and work out its report.
    function automatic report_t apply_op(logic [1:0] action, logic [DATA_W-1:0] raw);
        report_t r;
        int      v;
        int      pos;
        v = int'(raw);
        r.dropped = 1'b0;
        case (action)
            ACT_INSERT: begin
                if (sorted_vals.size() >= CAPACITY) begin
                    r.dropped = 1'b1;
                end else begin
                    pos = 0;
                    // upper position: after every equal value
                    while (pos < sorted_vals.size() && sorted_vals[pos] <= v)
                        pos++;
                    sorted_vals.insert(pos, v);
                end
            end
            ACT_DELETE: begin
                if (sorted_vals.size() > 0) begin
                    if (raw == DEL_MIN_CODE)
                        void'(sorted_vals.pop_front());
                    else
                        void'(sorted_vals.pop_back());
                end
            end
            ACT_CLEAR: begin
                sorted_vals.delete();
            end
            default: ;  // unused code: leave the queue alone
        endcase
        if (sorted_vals.size() == 0) begin
            r.is_empty  = 1'b1;
            r.max_value = '0;
            r.min_value = '0;
        end else begin
            r.is_empty  = 1'b0;
            r.max_value = sorted_vals[$];
            r.min_value = sorted_vals[0];
        end
        r.held_count = CNT_W'(sorted_vals.size());
        return r;
    endfunction

    function automatic void add_op(logic [1:0] action, logic [DATA_W-1:0] value, int phase,
                                   bit pause = 1'b0);
        op_t o;
        o.action = action;
        o.value  = value;
        o.phase  = phase;
        o.pause  = pause;
        pending_ops.push_back(o);
    endfunction

    // Random value: often from a narrow band or near the extremes so duplicates and ties are common.
    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return $urandom;
        else if (sel < 85)
            return DATA_W'($signed($urandom_range(16)) - 8);
        else if (sel < 92)
            return 32'h7fff_ffff - $urandom_range(2);
        else
            return 32'h8000_0000 + $urandom_range(2);
    endfunction

    // Mostly sensible traffic with a little noise, clears keep the depth small.
    function automatic void add_random(int phase, int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 52)
                add_op(ACT_INSERT, pick_value(), phase);
            else if (sel < 70)
                add_op(ACT_DELETE, DEL_MIN_CODE, phase);
            else if (sel < 88)
                add_op(ACT_DELETE, pick_value(), phase);
            else if (sel < 93)
                add_op(ACT_CLEAR, pick_value(), phase);
            else if (sel < 96)
                add_op(2'd3, pick_value(), phase);
            else
                add_op(2'(sel & 1), pick_value(), phase, 1'b1);
        end
    endfunction

    initial begin
        // directed opening: extremes, every action, empty and unused-code handling
        add_op(ACT_DELETE, DEL_MIN_CODE, 0);
        add_op(ACT_DELETE, '0, 0);
        add_op(ACT_INSERT, 32'h7fff_ffff, 0);
        add_op(ACT_INSERT, 32'h8000_0000, 0);
        add_op(ACT_INSERT, 32'hffff_ffff, 0);
        add_op(ACT_INSERT, '0, 0);
        add_op(ACT_INSERT, '0, 0);
        add_op(ACT_INSERT, 32'h7fff_ffff, 0);
        add_op(2'd3, 32'hffff_ffff, 0);
        add_op(ACT_DELETE, DEL_MIN_CODE, 0);
        add_op(ACT_DELETE, 32'h7fff_ffff, 0);
        add_op(ACT_DELETE, 32'hffff_fffe, 0);
        add_op(ACT_DELETE, 32'h8000_0000, 0);
        add_op(ACT_CLEAR, 32'hffff_ffff, 0);
        add_op(ACT_DELETE, DEL_MIN_CODE, 0);
        add_op(ACT_INSERT, 32'h5555_5555, 0);
        add_op(ACT_INSERT, 32'haaaa_aaaa, 0, 1'b1);
        add_op(ACT_DELETE, DEL_MIN_CODE, 0);
        add_op(ACT_DELETE, DEL_MIN_CODE, 0);
        add_random(0, 250);
        add_random(1, 250);
        // fill to capacity with ascending values so the shifts stay short
        add_op(ACT_CLEAR, '0, 2, 1'b1);
        for (int i = 0; i < CAPACITY + 3; i++)
            add_op(ACT_INSERT, 32'h8000_0000 + i * 32'h0040_0001, 2);
        add_op(ACT_DELETE, DEL_MIN_CODE, 2);
        add_op(ACT_INSERT, 32'h8000_0000, 2);
        add_op(ACT_INSERT, $urandom, 2);
        add_op(ACT_DELETE, '0, 2);
        add_op(ACT_INSERT, 32'h7fff_ffff, 2);
        add_op(ACT_INSERT, 32'h7fff_ffff, 2);
        add_op(ACT_CLEAR, '0, 2);
        add_random(2, 250);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_ops.size() == 0 && !s_valid && queued_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d reports across three idling mixes,", reports_seen);
        $display("including %0d refused inserts at full depth", drops_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && queued_reports.size() == 0 && m_valid !== 1'b1)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Driver: present the next pending item, hold it until accepted.
    always @(posedge aclk) begin
        logic next_valid;
        bit   taken;
        next_valid = s_valid;
        taken = s_valid && s_ready;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (taken) begin
                queued_reports.push_back(apply_op(s_action, s_value));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_ops.size() > 0) begin
                // hold off for a pause item until the queue has drained
                if (!(pending_ops[0].pause && (queued_reports.size() > 0 || m_valid))
                    && $urandom_range(99) >= send_idle[pending_ops[0].phase]) begin
                    op_t o;
                    o = pending_ops.pop_front();
                    cur_phase <= o.phase;
                    s_action  <= o.action;
                    s_value   <= o.value;
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
    end

    // Monitor: compare each accepted report with the oldest prediction.
    always @(posedge aclk) begin
        report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                reports_seen++;
                if (m_dropped) drops_seen++;
                if (queued_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report: count %0d", m_held_count);
                end else begin
                    want = queued_reports.pop_front();
                    if (m_is_empty !== want.is_empty || m_max_value !== want.max_value
                        || m_min_value !== want.min_value
                        || m_held_count !== want.held_count || m_dropped !== want.dropped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at report %0d: want e%0b max %0d min %0d",
                                      " n%0d d%0b, got e%0b max %0d min %0d n%0d d%0b"},
                                     reports_seen, want.is_empty, $signed(want.max_value),
                                     $signed(want.min_value), want.held_count, want.dropped,
                                     m_is_empty, m_max_value, m_min_value, m_held_count,
                                     m_dropped);
                    end
                end
            end
            m_ready <= $urandom_range(99) >= recv_idle[cur_phase];
        end
    end

    // Watchdog: count cycles with work outstanding and no handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (pending_ops.size() == 0 && !s_valid && queued_reports.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
rtl/dpq_pkg.sv
rtl/dpq_store.sv
rtl/double_ended_priority_queue.sv
bench/double_ended_priority_queue_test.sv
